// File: hw/rtl/esp_pkg.sv
// Shared types and constants for the equal-sum partition counter.
// Used by the arithmetic unit and the top level; depends on nothing.
package esp_pkg;

    localparam int SET_SIZE_W = 9;
    localparam int COUNT_W    = 30;

    localparam logic [COUNT_W-1:0] PRIME_MOD      = 30'd1000000007;
    localparam logic [COUNT_W:0]   PRIME_MOD_WIDE = 31'd1000000007;

    typedef logic [COUNT_W-1:0] t_count;

endpackage

// File: hw/rtl/esp_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Self-contained; a read in the cycle of a write to the same entry sees the old data.
module esp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16449
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

// File: hw/rtl/esp_modarith.sv
// Modular arithmetic for the counting table: sum of two residues and halving.
// Depends on esp_pkg for the prime and the count type.
module esp_modarith (
    input  esp_pkg::t_count i_a,
    input  esp_pkg::t_count i_b,
    output esp_pkg::t_count o_sum,
    output esp_pkg::t_count o_half
);
    import esp_pkg::*;

    logic [COUNT_W:0] sum_wide;
    logic [COUNT_W:0] odd_wide;

    always_comb begin
        sum_wide = {1'b0, i_a} + {1'b0, i_b};
        if (sum_wide >= PRIME_MOD_WIDE) begin
            sum_wide = sum_wide - PRIME_MOD_WIDE;
        end
        o_sum = sum_wide[COUNT_W-1:0];
    end

    // An odd residue becomes even once the prime is added, so the shift is exact.
    always_comb begin
        odd_wide = {1'b0, i_a} + PRIME_MOD_WIDE;
        if (i_a[0]) begin
            o_half = odd_wide[COUNT_W:1];
        end else begin
            o_half = {1'b0, i_a[COUNT_W-1:1]};
        end
    end

endmodule

// File: hw/rtl/equal_sum_partition_counter.sv
// Equal-sum partition counter: one result per request, modulo 1000000007.
// For an even total the time is set by the sweep of the counting table RAM, one update per cycle
// within each pass, with an idle gap state between passes.
// An odd total or an oversized half sum skips the table and answers zero. One request is in work at a time.
// A request that sweeps the table begins with a clearing pass over entries 0..half; reset clears control only.
// Synchronous active-low reset; the table RAM holds no reset.
module equal_sum_partition_counter #(
    parameter int MAX_SET_SIZE = 256,
    parameter int MAX_HALF_SUM = 16448
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [8:0] set_size, [15:9] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [29:0] partition_count, [31:30] zero
);
    import esp_pkg::*;

    localparam int NW  = $clog2(MAX_SET_SIZE + 1);
    localparam int KW  = NW + 1;
    localparam int AW  = $clog2(MAX_HALF_SUM + 1);
    localparam int PW  = 2 * NW + 1;
    localparam int CW0 = (PW > AW) ? PW : AW;
    localparam int CW  = (CW0 > SET_SIZE_W + 1) ? CW0 : SET_SIZE_W + 1;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_CALC       = 4'd1;
    localparam logic [3:0] S_DECIDE     = 4'd2;
    localparam logic [3:0] S_CLEAR      = 4'd3;
    localparam logic [3:0] S_GAP        = 4'd4;
    localparam logic [3:0] S_SWEEP      = 4'd5;
    localparam logic [3:0] S_FINAL_RD   = 4'd6;
    localparam logic [3:0] S_FINAL_WAIT = 4'd7;

    logic [3:0]    r_state, n_state;
    logic [NW-1:0] r_n, n_n;
    logic [PW-1:0] r_prod, n_prod;
    logic [AW-1:0] r_half, n_half;
    logic [AW-1:0] r_j, n_j;
    logic [KW-1:0] r_k, n_k;
    logic          r_zero, n_zero;
    logic          r_pv;
    logic [AW-1:0] r_pa;
    logic          r_ovalid, n_ovalid;
    t_count        r_odata, n_odata;

    logic [SET_SIZE_W-1:0] in_size;
    logic [PW-1:0]         half_full;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    t_count                ram_wdata;
    logic [AW-1:0]         raddr_a, raddr_b;
    t_count                rdata_a, rdata_b;
    t_count                sum_mod, half_mod;

    assign in_size   = s_tdata[SET_SIZE_W-1:0];
    assign half_full = r_prod >> 2;
    assign s_tready  = (r_state == S_IDLE);
    assign m_tvalid  = r_ovalid;
    assign m_tdata   = {2'b00, r_odata};

    // Pending update from the sweep has priority; it never coincides with clearing.
    assign ram_we    = (r_state == S_CLEAR) || r_pv;
    assign ram_waddr = r_pv ? r_pa : r_j;
    assign ram_wdata = r_pv ? sum_mod : ((r_j == '0) ? t_count'(1) : '0);

    always_comb begin
        raddr_a = r_j;
        raddr_b = '0;
        if (r_state == S_SWEEP) begin
            raddr_b = r_j - AW'(r_k);
        end else if (r_state == S_FINAL_RD || r_state == S_FINAL_WAIT) begin
            raddr_a = r_half;
        end
    end

    esp_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(MAX_HALF_SUM + 1)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_waddr  (ram_waddr),
        .i_wdata  (ram_wdata),
        .i_raddr_a(raddr_a),
        .i_raddr_b(raddr_b),
        .o_rdata_a(rdata_a),
        .o_rdata_b(rdata_b)
    );

    esp_modarith u_arith (
        .i_a   (rdata_a),
        .i_b   (rdata_b),
        .o_sum (sum_mod),
        .o_half(half_mod)
    );

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_prod   = r_prod;
        n_half   = r_half;
        n_j      = r_j;
        n_k      = r_k;
        n_zero   = r_zero;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;

        if (r_ovalid && m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (CW'(in_size) > CW'(MAX_SET_SIZE)) begin
                        n_n = NW'(MAX_SET_SIZE);
                    end else begin
                        n_n = NW'(in_size);
                    end
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_prod  = PW'(r_n) * (PW'(r_n) + PW'(1));
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_half = AW'(half_full);
                n_j    = '0;
                n_k    = KW'(1);
                // An odd total has no split; a half sum beyond the table is also answered with zero.
                if (r_prod[1] || (CW'(half_full) > CW'(MAX_HALF_SUM))) begin
                    n_zero  = 1'b1;
                    n_state = S_FINAL_WAIT;
                end else begin
                    n_zero  = 1'b0;
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                if (r_j == r_half) begin
                    n_state = S_GAP;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_GAP: begin
                // This idle state lets the last update of the previous pass land.
                if (CW'(r_k) > CW'(r_n) || CW'(r_k) > CW'(r_half)) begin
                    n_state = S_FINAL_RD;
                end else begin
                    n_j     = r_half;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (CW'(r_j) == CW'(r_k)) begin
                    n_k     = r_k + KW'(1);
                    n_state = S_GAP;
                end else begin
                    n_j = r_j - AW'(1);
                end
            end
            S_FINAL_RD: begin
                n_state = S_FINAL_WAIT;
            end
            S_FINAL_WAIT: begin
                if (!r_ovalid || m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_zero ? '0 : half_mod;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pv     <= (r_state == S_SWEEP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_prod  <= n_prod;
        r_half  <= n_half;
        r_j     <= n_j;
        r_k     <= n_k;
        r_zero  <= n_zero;
        r_pa    <= r_j;
        r_odata <= n_odata;
    end

    a_no_update_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_pv)
        else $error("table update pending during the clearing pass");

    a_idle_means_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !r_pv)
        else $error("new request accepted with a table update still in flight");

    a_sweep_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (CW'(r_j) >= CW'(r_k)))
        else $error("sweep index fell below the item value");

    a_result_below_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[COUNT_W-1:0] < PRIME_MOD))
        else $error("result is not a reduced residue");

endmodule
